// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file of this project.
// Depends on nothing; every macro samples on i_clk, and ASSERT_CLK is off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is disabled while the synchronous reset is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Clocked assertion that holds during reset too.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- hdl/b2d_pkg.sv -----
// Shared types, constants and a helper function for the decimal text converter.
// Depends on nothing.
`timescale 1ns / 1ps
package b2d_pkg;

    // A 64-bit value has at most twenty decimal digits.
    localparam int NUM_DIGITS = 20;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = 5;

    localparam logic [5:0] ASCII_ZERO = 6'd48;

    typedef logic [3:0]       t_digit;
    typedef logic [BCD_W-1:0] t_bcd;
    typedef logic [CNT_W-1:0] t_cnt;

    // Double-dabble correction: a digit of five or more gets three added.
    function automatic t_digit add3(input t_digit d);
        add3 = (d >= 4'd5) ? d + 4'd3 : d;
    endfunction

endpackage

// ----- hdl/b2d_dabble_stage.sv -----
// One pipeline stage of the binary to BCD conversion (shift and add three).
// Depends on b2d_pkg.
`timescale 1ns / 1ps
module b2d_dabble_stage #(
    parameter int PAD_W = 64,
    parameter int BPS   = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  logic [PAD_W-1:0] i_bin,
    input  b2d_pkg::t_bcd    i_bcd,
    output logic             o_valid,
    output logic [PAD_W-1:0] o_bin,
    output b2d_pkg::t_bcd    o_bcd
);

    logic             r_valid;
    logic [PAD_W-1:0] r_bin;
    b2d_pkg::t_bcd    r_bcd;
    logic [PAD_W-1:0] n_bin;
    b2d_pkg::t_bcd    n_bcd;

    // Shift BPS bits of the binary word into the BCD digits.
    always_comb begin
        logic [PAD_W-1:0] bin;
        b2d_pkg::t_bcd    bcd;
        bin = i_bin;
        bcd = i_bcd;
        for (int s = 0; s < BPS; s++) begin
            for (int d = 0; d < b2d_pkg::NUM_DIGITS; d++) begin
                bcd[4*d +: 4] = b2d_pkg::add3(bcd[4*d +: 4]);
            end
            bcd = {bcd[b2d_pkg::BCD_W-2:0], bin[PAD_W-1]};
            bin = {bin[PAD_W-2:0], 1'b0};
        end
        n_bin = bin;
        n_bcd = bcd;
    end

    // Valid bit under reset; payload only moves when the pipe advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
        end
    end

    assign o_valid = r_valid;
    assign o_bin   = r_bin;
    assign o_bcd   = r_bcd;

endmodule

// ----- hdl/b2d_emit.sv -----
// Digit serializer: drops leading zeros and sends one ASCII digit per cycle.
// Depends on b2d_pkg.
`timescale 1ns / 1ps
module b2d_emit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  b2d_pkg::t_bcd i_bcd,
    output logic          o_ready,
    output logic          o_valid,
    output logic [5:0]    o_digit_char,
    output logic          o_last
);

    b2d_pkg::t_bcd r_bcd;
    b2d_pkg::t_cnt r_cnt;
    b2d_pkg::t_cnt n_len;
    b2d_pkg::t_cnt idx;

    // Number of significant digits; zero still has one digit.
    always_comb begin
        n_len = b2d_pkg::t_cnt'(1);
        for (int d = 1; d < b2d_pkg::NUM_DIGITS; d++) begin
            if (i_bcd[4*d +: 4] != 4'd0) begin
                n_len = b2d_pkg::t_cnt'(d + 1);
            end
        end
    end

    assign o_ready = (r_cnt == '0);

    // Load a converted number when idle, otherwise count the digits down.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_ready) begin
            if (i_valid) begin
                r_cnt <= n_len;
            end
        end else begin
            r_cnt <= r_cnt - b2d_pkg::t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bcd <= i_bcd;
        end
    end

    // Current digit, most significant first.
    assign idx          = r_cnt - b2d_pkg::t_cnt'(1);
    assign o_valid      = !o_ready;
    assign o_digit_char = b2d_pkg::ASCII_ZERO + {2'b00, r_bcd[4*idx +: 4]};
    assign o_last       = (r_cnt == b2d_pkg::t_cnt'(1));

endmodule

// ----- hdl/binary_to_decimal_ascii.sv -----
// Each number passes the STAGES conversion stages (STAGES is 3 to 8, from VALUE_WIDTH)
// and then the digit serializer, which sends one digit per cycle, 1 to 20 digits.
// The serializer loads a new number only when idle, after the last digit of the one before;
// the conversion pipeline holds further numbers meanwhile.
// Reset: synchronous, active low, clears all valid bits and the digit counter.
// The receiver cannot stall; each digit is shown for exactly one cycle.
`timescale 1ns / 1ps
module binary_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [63:0] i_value,
    output logic       busy,
    output logic       o_valid,
    output logic [5:0] o_digit_char,
    output logic       o_last
);

    localparam int STAGES_MIN = (VALUE_WIDTH + 7) / 8;
    localparam int STAGES     = (STAGES_MIN < 3) ? 3 : STAGES_MIN;
    localparam int BPS        = (VALUE_WIDTH + STAGES - 1) / STAGES;
    localparam int PAD_W      = STAGES * BPS;

    logic             adv;
    logic             emit_ready;
    logic [PAD_W-1:0] pad_value;
    logic             st_valid [STAGES+1];
    logic [PAD_W-1:0] st_bin   [STAGES+1];
    b2d_pkg::t_bcd    st_bcd   [STAGES+1];

    // Zero-extend the used bits of the value to the pipeline width.
    always_comb begin
        pad_value = '0;
        pad_value[VALUE_WIDTH-1:0] = i_value[VALUE_WIDTH-1:0];
    end

    // The whole pipe moves unless its last stage waits on the serializer.
    assign adv  = !(st_valid[STAGES] && !emit_ready);
    assign busy = !adv;

    assign st_valid[0] = start;
    assign st_bin[0]   = pad_value;
    assign st_bcd[0]   = '0;

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        b2d_dabble_stage #(
            .PAD_W (PAD_W),
            .BPS   (BPS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (st_valid[g]),
            .i_bin   (st_bin[g]),
            .i_bcd   (st_bcd[g]),
            .o_valid (st_valid[g+1]),
            .o_bin   (st_bin[g+1]),
            .o_bcd   (st_bcd[g+1])
        );
    end

    b2d_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (st_valid[STAGES]),
        .i_bcd        (st_bcd[STAGES]),
        .o_ready      (emit_ready),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

endmodule

// ----- hdl/b2d_checker.sv -----
// Port-level checks on the decimal text converter, bound to its top level.
// Depends on assert_macros.svh and binary_to_decimal_ascii.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module b2d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic [63:0] i_value,
    input logic        busy,
    input logic        o_valid,
    input logic [5:0]  o_digit_char,
    input logic        o_last
);

    // Every digit transfer carries an ASCII decimal digit.
    `ASSERT_CLK(a_digit, o_valid |-> (o_digit_char >= 6'd48 && o_digit_char <= 6'd57), "bad digit")

    // The digits of one number come in consecutive cycles.
    `ASSERT_CLK(a_contiguous, (o_valid && !o_last) |=> o_valid, "gap inside a number")

    // The last flag only marks a real digit.
    `ASSERT_CLK(a_last_valid, o_last |-> o_valid, "last without digit")

    // Nothing comes out in the cycle after one with reset asserted.
    `ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_valid, "output after reset")

endmodule

bind binary_to_decimal_ascii b2d_checker u_b2d_checker (.*);

// ----- verif/testbench.sv -----
// Self-checking testbench for the binary to decimal ASCII converter.
// Depends on hdl/b2d_pkg.sv and hdl/binary_to_decimal_ascii.sv.
`timescale 1ns / 1ps
module testbench;

    localparam int VALUE_WIDTH = 64;
    localparam int N_RANDOM    = 350;
    localparam logic [5:0] CHAR_ZERO = b2d_pkg::ASCII_ZERO;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic [63:0] i_value;
    logic        busy;
    logic        o_valid;
    logic [5:0]  o_digit_char;
    logic        o_last;

    typedef struct packed {
        logic [5:0] digit_char;
        logic       last;
    } t_digit_item;

    int error_count = 0;

    // One line per mismatch, counted for the final verdict.
    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Predicts the digit string for each number and checks digits in order.
    class digit_scoreboard;
        t_digit_item pending_digits[$];

        function void note_number(input logic [63:0] value);
            logic [63:0] v;
            t_digit_item rev[$];
            t_digit_item item;
            v = (VALUE_WIDTH >= 64) ? value : (value & ((64'd1 << VALUE_WIDTH) - 1));
            do begin
                item.digit_char = CHAR_ZERO + 6'(v % 64'd10);
                item.last       = 1'b0;
                rev.push_front(item);
                v = v / 64'd10;
            end while (v != 64'd0);
            rev[rev.size() - 1].last = 1'b1;
            foreach (rev[k]) pending_digits.push_back(rev[k]);
        endfunction

        task check_digit(input logic [5:0] digit_char, input logic last);
            t_digit_item exp_item;
            if (pending_digits.size() == 0) begin
                report($sformatf("unexpected digit %0d last %0b", digit_char, last));
            end else begin
                exp_item = pending_digits.pop_front();
                if (digit_char !== exp_item.digit_char)
                    report($sformatf("digit_char %0d, expected %0d",
                                     digit_char, exp_item.digit_char));
                if (last !== exp_item.last)
                    report($sformatf("last %0b, expected %0b", last, exp_item.last));
            end
        endtask
    endclass

    digit_scoreboard digits_sb;

    binary_to_decimal_ascii #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_value     (i_value),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_digit_char(o_digit_char),
        .o_last      (o_last)
    );

    // Clock, 12 ns period.
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Results are sampled at the edge that accepts them.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) digits_sb.check_digit(o_digit_char, o_last);
    end

    // Holds start and the value until the transfer happens.
    task automatic send_number(input logic [63:0] value, input bit allow_gap);
        if (allow_gap && ($urandom_range(0, 3) == 0)) begin
            start <= 1'b0;
            i_value <= {$urandom, $urandom};
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (busy);
        digits_sb.note_number(value);
    endtask

    // Random value with a random bit length, so short and long numbers mix.
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        int bits;
        v = {$urandom, $urandom};
        bits = $urandom_range(1, 64);
        if (bits < 64) v = v & ((64'd1 << bits) - 1);
        return v;
    endfunction

    initial begin
        logic [63:0] p10;
        int n;
        digits_sb = new();
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_value = 64'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: zero, extremes, bit patterns, powers of ten and the values just below them.
        send_number(64'd0, 0);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_number(64'd9, 0);
        send_number(64'd10, 0);
        send_number(64'hAAAA_AAAA_AAAA_AAAA, 0);
        send_number(64'h5555_5555_5555_5555, 0);
        send_number(64'h0000_0000_FFFF_FFFF, 0);
        send_number(64'h0000_0001_0000_0000, 0);
        send_number(64'h8000_0000_0000_0000, 0);
        p10 = 64'd100;
        for (int k = 0; k < 8; k++) begin
            send_number(p10 - 64'd1, 0);
            send_number(p10, 0);
            p10 = p10 * 64'd1000;
        end

        // Random part, with gaps in the first stretch and none at the end.
        n = 0;
        while (n < N_RANDOM) begin
            send_number(random_value(), n < N_RANDOM - 60);
            n++;
        end
        start <= 1'b0;

        // Drain, then allow the pipeline latency to pass.
        while (digits_sb.pending_digits.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #(12 * 200000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
